@@ rtl/background_subtract_motion_mask_top_defines.svh @@
// Assertion macros for the background subtraction motion mask block.
// Taken in by the top level; no other dependencies.
`ifndef BACKGROUND_SUBTRACT_MOTION_MASK_TOP_DEFINES_SVH
`define BACKGROUND_SUBTRACT_MOTION_MASK_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BSMM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define BSMM_ASSERT_FOLLOWS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BSMM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define BSMM_ASSERT_FOLLOWS(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/bsmm_pkg.sv @@
// Shared types and constants of the background subtraction motion mask block.
// No dependencies.
package bsmm_pkg;

  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int THR_W      = 8;
  localparam int WARM_W     = 6;
  localparam int CNT_W      = 14;
  localparam int COLSUM_W   = 10;  // three 8-bit diffs
  localparam int SUM_W      = 12;  // nine 8-bit diffs, also 9 * threshold
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;
  localparam logic [Q_CNT_W-1:0] Q_FULL_LEVEL = Q_CNT_W'(Q_DEPTH);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIFF_THRESHOLD = 2'd0,
    REG_WARMUP_FRAMES  = 2'd1,
    REG_RESTART_LIMIT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0]  diff_threshold;
    logic [WARM_W-1:0] warmup_frames;
    logic [CNT_W-1:0]  restart_count_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    diff_threshold:      8'd40,
    warmup_frames:       6'd40,
    restart_count_limit: 14'd8110
  };

  // classification made by the front end for each pixel
  typedef struct packed {
    logic first;     // row 0, column 0
    logic interior;  // row >= 2 and column >= 2: window centre is interior
    logic last;      // last pixel of the frame
  } item_flags_t;

  typedef struct packed {
    logic pop;   // back end takes the queue head
    logic busy;  // items in flight past the queue
  } back_status_t;

endpackage

@@ rtl/background_subtract_motion_mask_top.sv @@
// Background subtraction motion mask: top level with configuration registers.
// Depends on bsmm_pkg, bsmm_front, bsmm_queue, bsmm_back and the defines header.
//
// Pixels arrive in raster order on the pix channel (pix_valid/pix_stall) with
// red, green, blue and frame_start. The first warmup_frames frames after reset
// or a restart are stored as background; later frames are compared against it.
// One mask item leaves on the mask channel (mask_valid/mask_stall) for every
// pixel whose 3x3 window centre is interior, one row and one column behind the
// incoming pixel; border pixels give no item. The item for the last pixel of a
// frame carries frame_done, the frame's marked count and learning_restarted.
// Registers are written through cfg_valid/cfg_ready (always ready) with
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. A mask item passes the queue,
// the stage 2, 3 and 4 registers and the output register. Throughput is one
// pixel per cycle while the queue has room and mask_stall holds nothing back;
// the first pixel of each frame waits for the back-end pipeline to drain. A
// 4-entry queue separates the pixel front end from the back end.
// Reset is synchronous; the background memory is not cleared. While mask_stall
// blocks a valid item the pipeline holds, the queue fills, then pix_stall rises.
`include "background_subtract_motion_mask_top_defines.svh"
module background_subtract_motion_mask_top #(
  parameter int FRAME_WIDTH  = 128,
  parameter int FRAME_HEIGHT = 96,
  localparam int ROW_W = $clog2(FRAME_HEIGHT),
  localparam int COL_W = $clog2(FRAME_WIDTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsmm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            pix_valid,
  output logic                            pix_stall,
  input  logic [bsmm_pkg::PIX_W-1:0]      red,
  input  logic [bsmm_pkg::PIX_W-1:0]      green,
  input  logic [bsmm_pkg::PIX_W-1:0]      blue,
  input  logic                            frame_start,
  output logic                            mask_valid,
  input  logic                            mask_stall,
  output logic [ROW_W-1:0]                row,
  output logic [COL_W-1:0]                col,
  output logic                            marked,
  output logic                            frame_done,
  output logic [bsmm_pkg::CNT_W-1:0]      marked_count,
  output logic                            learning_restarted
);
  import bsmm_pkg::*;

  localparam int POS_W = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
  localparam int FLAG_W = $bits(item_flags_t);
  localparam int Q_W = POS_W + ROW_W + COL_W + RGB_W + FLAG_W;

  cfg_t cfg;

  logic             push;
  logic [ROW_W-1:0] f_row;
  logic [COL_W-1:0] f_col;
  logic [POS_W-1:0] f_pos;
  logic [RGB_W-1:0] f_rgb;
  item_flags_t      f_flags;

  logic [Q_W-1:0]   q_head;
  logic             q_full;
  logic             q_empty;

  logic [ROW_W-1:0] head_row;
  logic [COL_W-1:0] head_col;
  logic [POS_W-1:0] head_pos;
  logic [RGB_W-1:0] head_rgb;
  item_flags_t      head_flags;
  back_status_t     status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIFF_THRESHOLD: cfg.diff_threshold      <= cfg_data[THR_W-1:0];
        REG_WARMUP_FRAMES:  cfg.warmup_frames       <= cfg_data[WARM_W-1:0];
        REG_RESTART_LIMIT:  cfg.restart_count_limit <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  bsmm_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .frame_start(frame_start),
    .q_full     (q_full),
    .push       (push),
    .item_row   (f_row),
    .item_col   (f_col),
    .item_pos   (f_pos),
    .item_rgb   (f_rgb),
    .item_flags (f_flags)
  );

  bsmm_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({f_pos, f_row, f_col, f_rgb, f_flags}),
    .pop      (status.pop),
    .head_data(q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  assign {head_pos, head_row, head_col, head_rgb, head_flags} = q_head;

  bsmm_back #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .q_empty           (q_empty),
    .head_row          (head_row),
    .head_col          (head_col),
    .head_pos          (head_pos),
    .head_rgb          (head_rgb),
    .head_flags        (head_flags),
    .status            (status),
    .mask_valid        (mask_valid),
    .mask_stall        (mask_stall),
    .row               (row),
    .col               (col),
    .marked            (marked),
    .frame_done        (frame_done),
    .marked_count      (marked_count),
    .learning_restarted(learning_restarted)
  );

  `BSMM_ASSERT_IMPLIES(a_pop_nonempty, clk, rst, status.pop, !q_empty, "pop from empty queue")
  `BSMM_ASSERT_IMPLIES(a_first_drained, clk, rst, (status.pop && head_flags.first), !status.busy, "frame start issued with items in flight")
  `BSMM_ASSERT_IMPLIES(a_count_on_done, clk, rst, (mask_valid && !frame_done), (!learning_restarted && (marked_count == '0)), "frame result outside frame end")
  `BSMM_ASSERT_FOLLOWS(a_push_lands, clk, rst, (pix_valid && !pix_stall), !q_empty, "accepted pixel missing from queue")

endmodule

@@ rtl/bsmm_front.sv @@
// Front end: accepts pixels, tracks row, column and frame position, classifies.
// Depends on bsmm_pkg.
module bsmm_front #(
  parameter int FRAME_WIDTH  = 128,
  parameter int FRAME_HEIGHT = 96,
  localparam int ROW_W = $clog2(FRAME_HEIGHT),
  localparam int COL_W = $clog2(FRAME_WIDTH),
  localparam int POS_W = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pix_valid,
  output logic                     pix_stall,
  input  logic [bsmm_pkg::PIX_W-1:0] red,
  input  logic [bsmm_pkg::PIX_W-1:0] green,
  input  logic [bsmm_pkg::PIX_W-1:0] blue,
  input  logic                     frame_start,
  input  logic                     q_full,
  output logic                     push,
  output logic [ROW_W-1:0]         item_row,
  output logic [COL_W-1:0]         item_col,
  output logic [POS_W-1:0]         item_pos,
  output logic [bsmm_pkg::RGB_W-1:0] item_rgb,
  output bsmm_pkg::item_flags_t    item_flags
);
  import bsmm_pkg::*;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);

  logic [ROW_W-1:0] row_cnt, row_cnt_next;
  logic [COL_W-1:0] col_cnt, col_cnt_next;
  logic [POS_W-1:0] pos_cnt, pos_cnt_next;

  assign pix_stall = q_full;
  assign push      = pix_valid && !q_full;

  assign item_row = frame_start ? '0 : row_cnt;
  assign item_col = frame_start ? '0 : col_cnt;
  assign item_pos = frame_start ? '0 : pos_cnt;
  assign item_rgb = {red, green, blue};

  always_comb begin
    item_flags.first    = (item_row == '0) && (item_col == '0);
    item_flags.interior = (item_row >= ROW_W'(2)) && (item_col >= COL_W'(2));
    item_flags.last     = (item_row == ROW_LAST) && (item_col == COL_LAST);
  end

  // raster advance; past the last pixel the position wraps to a new frame
  always_comb begin
    if (item_col == COL_LAST) begin
      col_cnt_next = '0;
      row_cnt_next = (item_row == ROW_LAST) ? '0 : item_row + ROW_W'(1);
    end else begin
      col_cnt_next = item_col + COL_W'(1);
      row_cnt_next = item_row;
    end
    pos_cnt_next = item_flags.last ? '0 : item_pos + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
      pos_cnt <= '0;
    end else if (push) begin
      row_cnt <= row_cnt_next;
      col_cnt <= col_cnt_next;
      pos_cnt <= pos_cnt_next;
    end
  end

endmodule

@@ rtl/bsmm_queue.sv @@
// Short FIFO between the front end and the back end.
// Depends on bsmm_pkg for its depth.
module bsmm_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output logic              full,
  output logic              empty
);
  import bsmm_pkg::*;

  logic [DATA_W-1:0]  entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full      = (count == Q_FULL_LEVEL);
  assign empty     = (count == '0);
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/bsmm_back.sv @@
// Back end: background store, difference, line buffers, 3x3 window sum,
// threshold, frame count and warm-up control. Depends on bsmm_pkg.
module bsmm_back #(
  parameter int FRAME_WIDTH  = 128,
  parameter int FRAME_HEIGHT = 96,
  localparam int ROW_W = $clog2(FRAME_HEIGHT),
  localparam int COL_W = $clog2(FRAME_WIDTH),
  localparam int POS_W = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bsmm_pkg::cfg_t             cfg,
  input  logic                       q_empty,
  input  logic [ROW_W-1:0]           head_row,
  input  logic [COL_W-1:0]           head_col,
  input  logic [POS_W-1:0]           head_pos,
  input  logic [bsmm_pkg::RGB_W-1:0] head_rgb,
  input  bsmm_pkg::item_flags_t      head_flags,
  output bsmm_pkg::back_status_t     status,
  output logic                       mask_valid,
  input  logic                       mask_stall,
  output logic [ROW_W-1:0]           row,
  output logic [COL_W-1:0]           col,
  output logic                       marked,
  output logic                       frame_done,
  output logic [bsmm_pkg::CNT_W-1:0] marked_count,
  output logic                       learning_restarted
);
  import bsmm_pkg::*;

  localparam int BG_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // memories: background frame and the two previous rows of differences
  logic [RGB_W-1:0]   bg_mem   [BG_DEPTH];
  logic [2*PIX_W-1:0] line_mem [FRAME_WIDTH];
  logic [RGB_W-1:0]   bg_q;
  logic [2*PIX_W-1:0] line_q;

  logic             adv;
  logic             pop;
  logic             capture_now;
  logic             capturing;
  logic [WARM_W-1:0] warm_cnt;

  // stage 2: memory data in hand, difference
  logic              p2_valid;
  item_flags_t       p2_flags;
  logic [ROW_W-1:0]  p2_row;
  logic [COL_W-1:0]  p2_col;
  logic [RGB_W-1:0]  p2_rgb;
  logic              p2_cap;
  logic [2*PIX_W-1:0] p2_line;
  logic [PIX_W-1:0]  p2_dr, p2_dg, p2_db, p2_drg, p2_d;

  // last line buffer write, forwarded to a read issued in the same cycle
  logic              lw_valid;
  logic [COL_W-1:0]  lw_col;
  logic [2*PIX_W-1:0] lw_data;

  // stage 3: column sum and window sum
  logic              p3_valid;
  item_flags_t       p3_flags;
  logic [ROW_W-1:0]  p3_row;
  logic [COL_W-1:0]  p3_col;
  logic [PIX_W-1:0]  p3_d, p3_up1, p3_up2;
  logic [COLSUM_W-1:0] p3_colsum;
  logic [COLSUM_W-1:0] cs_prev1, cs_prev2;
  logic [SUM_W-1:0]  p3_sum;

  // stage 4: threshold and frame count
  logic              p4_valid;
  item_flags_t       p4_flags;
  logic [ROW_W-1:0]  p4_row;
  logic [COL_W-1:0]  p4_col;
  logic [SUM_W-1:0]  p4_sum;
  logic [SUM_W-1:0]  thr9;
  logic              p4_mark;
  logic [CNT_W-1:0]  count_base;
  logic [CNT_W-1:0]  count_new;
  logic              p4_restart;
  logic [CNT_W-1:0]  frame_count;

  // whole pipeline moves together whenever the output register can take an item
  assign adv         = !mask_valid || !mask_stall;
  assign status.busy = p2_valid || p3_valid || p4_valid;
  // a frame's first pixel waits until the previous frame's restart is settled
  assign pop         = adv && !q_empty && !(head_flags.first && status.busy);
  assign status.pop  = pop;

  assign capture_now = head_flags.first ? (warm_cnt < cfg.warmup_frames) : capturing;

  always_ff @(posedge clk) begin
    if (pop && capture_now) begin
      bg_mem[head_pos] <= head_rgb;
    end
    if (adv) begin
      bg_q <= bg_mem[head_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p2_valid) begin
      line_mem[p2_col] <= {p2_line[PIX_W-1:0], p2_d};
    end
    if (adv) begin
      line_q <= line_mem[head_col];
    end
  end

  // stage 2 logic
  always_comb begin
    p2_line = (lw_valid && (lw_col == p2_col)) ? lw_data : line_q;
    p2_dr   = abs_diff(bg_q[2*PIX_W +: PIX_W], p2_rgb[2*PIX_W +: PIX_W]);
    p2_dg   = abs_diff(bg_q[PIX_W +: PIX_W], p2_rgb[PIX_W +: PIX_W]);
    p2_db   = abs_diff(bg_q[0 +: PIX_W], p2_rgb[0 +: PIX_W]);
    p2_drg  = (p2_dg > p2_dr) ? p2_dg : p2_dr;
    p2_d    = p2_cap ? '0 : ((p2_db > p2_drg) ? p2_db : p2_drg);
  end

  // stage 3 logic: sum of this column plus the two previous columns
  always_comb begin
    p3_colsum = COLSUM_W'(p3_up2) + COLSUM_W'(p3_up1) + COLSUM_W'(p3_d);
    p3_sum    = SUM_W'(p3_colsum) + SUM_W'(cs_prev1) + SUM_W'(cs_prev2);
  end

  // stage 4 logic
  always_comb begin
    thr9       = SUM_W'({cfg.diff_threshold, 3'b000}) + SUM_W'(cfg.diff_threshold);
    p4_mark    = p4_sum > thr9;
    count_base = p4_flags.first ? '0 : frame_count;
    count_new  = (p4_flags.interior && p4_mark && (count_base != COUNT_MAX)) ?
                 count_base + CNT_W'(1) : count_base;
    p4_restart = p4_flags.interior && p4_flags.last &&
                 (count_new > cfg.restart_count_limit);
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_flags <= head_flags;
      p2_row   <= head_row;
      p2_col   <= head_col;
      p2_rgb   <= head_rgb;
      p2_cap   <= capture_now;
      lw_col   <= p2_col;
      lw_data  <= {p2_line[PIX_W-1:0], p2_d};
      p3_flags <= p2_flags;
      p3_row   <= p2_row;
      p3_col   <= p2_col;
      p3_d     <= p2_d;
      p3_up1   <= p2_line[PIX_W-1:0];
      p3_up2   <= p2_line[2*PIX_W-1:PIX_W];
      p4_flags <= p3_flags;
      p4_row   <= p3_row;
      p4_col   <= p3_col;
      p4_sum   <= p3_sum;
    end
    if (adv && p4_valid && p4_flags.interior) begin
      row                <= p4_row - ROW_W'(1);
      col                <= p4_col - COL_W'(1);
      marked             <= p4_mark;
      frame_done         <= p4_flags.last;
      marked_count       <= p4_flags.last ? count_new : '0;
      learning_restarted <= p4_restart;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid    <= 1'b0;
      p3_valid    <= 1'b0;
      p4_valid    <= 1'b0;
      lw_valid    <= 1'b0;
      mask_valid  <= 1'b0;
      capturing   <= 1'b0;
      warm_cnt    <= '0;
      frame_count <= '0;
      cs_prev1    <= '0;
      cs_prev2    <= '0;
    end else begin
      if (adv) begin
        p2_valid   <= pop;
        p3_valid   <= p2_valid;
        p4_valid   <= p3_valid;
        lw_valid   <= p2_valid;
        mask_valid <= p4_valid && p4_flags.interior;
      end
      if (pop && head_flags.first) begin
        capturing <= capture_now;
        if (capture_now) begin
          warm_cnt <= warm_cnt + WARM_W'(1);
        end
      end
      if (adv && p3_valid) begin
        cs_prev2 <= cs_prev1;
        cs_prev1 <= p3_colsum;
      end
      if (adv && p4_valid) begin
        frame_count <= count_new;
        if (p4_restart) begin
          warm_cnt <= '0;
        end
      end
    end
  end

endmodule
